// ----- src/dpss_pkg.sv -----
// shared types and constants for the drive power state sequencer
package dpss_pkg;

  localparam int AXES = 8;
  localparam int AXIS_W = 3;
  localparam int AXIS_IDX_W = (AXES > 1) ? $clog2(AXES) : 1;

  localparam int IN_DATA_W = 88;
  localparam int OUT_DATA_W = 96;

  localparam logic signed [7:0] MODE_RESET = 8'sd7;
  localparam logic signed [7:0] MODE_IP_POS = 8'sd7;

  localparam logic [15:0] MASK_FULL = 16'h006F;
  localparam logic [15:0] MASK_NO5 = 16'h004F;

  localparam logic [15:0] ST_NOTREADY = 16'h0000;
  localparam logic [15:0] ST_SODISABLED = 16'h0040;
  localparam logic [15:0] ST_READY = 16'h0021;
  localparam logic [15:0] ST_SWITCHEDON = 16'h0023;
  localparam logic [15:0] ST_OPENABLED = 16'h0027;
  localparam logic [15:0] ST_QUICKSTOP = 16'h0007;
  localparam logic [15:0] ST_FAULTREACT = 16'h000F;
  localparam logic [15:0] ST_FAULT = 16'h0008;

  localparam logic [15:0] CW_SHUTDOWN = 16'h0006;
  localparam logic [15:0] CW_SWITCHON = 16'h0007;
  localparam logic [15:0] CW_ENABLEOP = 16'h000F;
  localparam logic [15:0] CW_IPPOS = 16'h001F;
  localparam logic [15:0] CW_DISABLEV = 16'h0000;
  localparam logic [15:0] CW_FAULTRESET = 16'h0080;

  localparam logic [3:0] BOOT_START = 4'd0;
  localparam logic [3:0] BOOT_WAIT = 4'd1;
  localparam logic [3:0] BOOT_DELAY0 = 4'd9;
  localparam logic [3:0] BOOT_DELAY1 = 4'd10;
  localparam logic [3:0] BOOT_DELAY2 = 4'd11;
  localparam logic [3:0] BOOT_SHUTDOWN = 4'd12;
  localparam logic [3:0] BOOT_DONE = 4'd13;

  localparam logic [2:0] FAULT_WAIT_LIMIT = 3'd5;

  localparam logic [1:0] DS_SO_DISABLED = 2'd0;
  localparam logic [1:0] DS_READY = 2'd1;
  localparam logic [1:0] DS_OP_ENABLED = 2'd2;
  localparam logic [1:0] DS_FAULT = 2'd3;

  typedef struct packed {
    logic              error_ack;
    logic signed [31:0] actual_position;
    logic signed [31:0] set_position;
    logic              drive_enable;
    logic              module_ok;
    logic [15:0]       status_word;
    logic [AXIS_W-1:0] axis_index;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         drive_state;
    logic               booted;
    logic               encoder_ok;
    logic               drive_ok;
    logic               drive_ready;
    logic signed [31:0] target_offset;
    logic signed [31:0] target_pos;
    logic [15:0]        control_word;
    logic [AXIS_W-1:0]  axis_out;
  } out_item_t;

endpackage

// ----- src/drive_power_state_sequencer.sv -----
// top level: per-axis drive power state machine, master side
//
//   channel   dir  handshake            payload
//   s_axis    in   s_tvalid / s_tready  s_tdata, 88 bits
//   m_axis    out  m_tvalid / m_tready  m_tdata, 96 bits
//   cfg       in   cfg_wen              cfg_wdata, operation mode
//
// one item per clock unless the result stalls; input register, then result register
// per-axis state lives in flip-flops and is updated as the item moves to the result register
// reset initialises all per-axis state at once, no clearing pass
// a stalled result holds; the input register keeps taking items until both stages are full
module drive_power_state_sequencer
  import dpss_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // axis_index, status_word, module_ok, drive_enable, set_position,
  // actual_position, error_ack, zero pad
  input  logic [IN_DATA_W-1:0]  s_tdata,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // axis_out, control_word, target_pos, target_offset, drive_ready,
  // drive_ok, encoder_ok, booted, drive_state, zero pad
  output logic [OUT_DATA_W-1:0] m_tdata,
  input  logic                  cfg_wen,
  input  logic [7:0]            cfg_wdata
);

  logic signed [7:0] operation_mode;

  logic     in_valid;
  in_item_t in_item;
  logic     out_valid;
  out_item_t out_item;
  logic     advance;

  logic [15:0]        last_masked_state [AXES];
  logic [3:0]         boot_step         [AXES];
  logic [2:0]         fault_wait        [AXES];
  logic               ack_latched       [AXES];
  logic               booted_flag       [AXES];
  logic               ready_flag        [AXES];
  logic               ok_flag           [AXES];
  logic               enc_ok_flag       [AXES];
  logic [31:0]        last_setpoint     [AXES];
  logic [15:0]        current_control   [AXES];
  logic [31:0]        held_target       [AXES];
  logic [31:0]        held_offset       [AXES];
  logic [1:0]         state_code        [AXES];

  logic                  in_range;
  logic [AXIS_IDX_W-1:0] idx;

  logic [15:0] last_masked_state_next;
  logic [3:0]  boot_step_next;
  logic [2:0]  fault_wait_next;
  logic        ack_latched_next;
  logic        booted_flag_next;
  logic        ready_flag_next;
  logic        ok_flag_next;
  logic        enc_ok_flag_next;
  logic [31:0] last_setpoint_next;
  logic [15:0] current_control_next;
  logic [31:0] held_target_next;
  logic [31:0] held_offset_next;
  logic [1:0]  state_code_next;
  out_item_t   out_item_next;

  logic [15:0] ts;
  logic [15:0] tn;

  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;
  assign m_tvalid = out_valid;
  assign m_tdata  = {{(OUT_DATA_W - $bits(out_item_t)){1'b0}}, out_item};

  always_ff @(posedge clk) begin
    if (rst) begin
      operation_mode <= MODE_RESET;
    end else if (cfg_wen) begin
      operation_mode <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_item <= in_item_t'(s_tdata[$bits(in_item_t)-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item <= out_item_next;
    end
  end

  assign in_range = ({1'b0, in_item.axis_index} < (AXIS_W + 1)'(AXES));
  assign idx = AXIS_IDX_W'(in_item.axis_index);
  assign ts = in_item.status_word & MASK_FULL;
  assign tn = in_item.status_word & MASK_NO5;

  always_comb begin
    last_masked_state_next = last_masked_state[idx];
    boot_step_next         = boot_step[idx];
    fault_wait_next        = fault_wait[idx];
    ack_latched_next       = ack_latched[idx] | in_item.error_ack;
    booted_flag_next       = booted_flag[idx];
    ready_flag_next        = ready_flag[idx];
    ok_flag_next           = ok_flag[idx];
    enc_ok_flag_next       = enc_ok_flag[idx];
    last_setpoint_next     = last_setpoint[idx];
    current_control_next   = current_control[idx];
    held_target_next       = held_target[idx];
    held_offset_next       = held_offset[idx];
    state_code_next        = state_code[idx];

    if (ready_flag[idx]) begin
      if (in_item.drive_enable) begin
        if (operation_mode == MODE_IP_POS) begin
          held_target_next = in_item.set_position;
        end
      end else begin
        held_offset_next = in_item.actual_position - in_item.set_position;
      end
    end

    if (last_masked_state[idx] != ts) begin
      last_masked_state_next = ts;
      boot_step_next = BOOT_START;
      fault_wait_next = '0;
    end
    if (!in_item.module_ok) begin
      booted_flag_next = 1'b0;
    end

    if (tn == ST_NOTREADY) begin
      ready_flag_next = 1'b0;
    end else if (tn == ST_SODISABLED || !booted_flag_next) begin
      ready_flag_next = 1'b0;
      ok_flag_next = 1'b1;
      state_code_next = DS_SO_DISABLED;
      case (boot_step_next)
        BOOT_START: boot_step_next = BOOT_WAIT;
        BOOT_WAIT: boot_step_next = BOOT_DELAY0;
        BOOT_DELAY0, BOOT_DELAY1, BOOT_DELAY2: boot_step_next = boot_step_next + 4'd1;
        BOOT_SHUTDOWN: begin
          current_control_next = CW_SHUTDOWN;
          boot_step_next = BOOT_DONE;
        end
        BOOT_DONE: booted_flag_next = 1'b1;
        default: boot_step_next = boot_step_next;
      endcase
    end else if (ts == ST_READY) begin
      if (!ready_flag_next) begin
        ready_flag_next = 1'b1;
      end else if (in_item.drive_enable) begin
        current_control_next = CW_SWITCHON;
      end
      state_code_next = DS_READY;
    end else if (ts == ST_SWITCHEDON) begin
      current_control_next = CW_ENABLEOP;
      last_setpoint_next = in_item.set_position;
    end else if (ts == ST_OPENABLED) begin
      if (in_item.set_position != last_setpoint[idx]) begin
        last_setpoint_next = in_item.set_position;
        current_control_next = CW_IPPOS;
      end
      if (!in_item.drive_enable) begin
        current_control_next = CW_SHUTDOWN;
        ready_flag_next = 1'b0;
      end
      state_code_next = DS_OP_ENABLED;
    end else if (ts == ST_QUICKSTOP || tn == ST_FAULTREACT) begin
      state_code_next = state_code[idx];
    end else if (tn == ST_FAULT) begin
      ok_flag_next = 1'b0;
      ready_flag_next = 1'b0;
      if (fault_wait_next > FAULT_WAIT_LIMIT) begin
        if (ack_latched_next) begin
          current_control_next = CW_FAULTRESET;
          ack_latched_next = 1'b0;
          fault_wait_next = '0;
          enc_ok_flag_next = 1'b1;
          ok_flag_next = 1'b1;
        end else begin
          current_control_next = CW_DISABLEV;
        end
      end else begin
        fault_wait_next = fault_wait_next + 3'd1;
      end
      state_code_next = DS_FAULT;
    end

    out_item_next = '0;
    out_item_next.axis_out = in_item.axis_index;
    if (in_range) begin
      out_item_next.control_word    = current_control_next;
      out_item_next.target_pos      = held_target_next;
      out_item_next.target_offset   = held_offset_next;
      out_item_next.drive_ready     = ready_flag_next;
      out_item_next.drive_ok        = ok_flag_next;
      out_item_next.encoder_ok      = enc_ok_flag_next;
      out_item_next.booted          = booted_flag_next;
      out_item_next.drive_state     = state_code_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int a = 0; a < AXES; a++) begin
        last_masked_state[a] <= '0;
        boot_step[a]         <= '0;
        fault_wait[a]        <= '0;
        ack_latched[a]       <= 1'b0;
        booted_flag[a]       <= 1'b0;
        ready_flag[a]        <= 1'b0;
        ok_flag[a]           <= 1'b1;
        enc_ok_flag[a]       <= 1'b1;
        last_setpoint[a]     <= '0;
        current_control[a]   <= '0;
        held_target[a]       <= '0;
        held_offset[a]       <= '0;
        state_code[a]        <= DS_SO_DISABLED;
      end
    end else if (advance && in_range) begin
      last_masked_state[idx] <= last_masked_state_next;
      boot_step[idx]         <= boot_step_next;
      fault_wait[idx]        <= fault_wait_next;
      ack_latched[idx]       <= ack_latched_next;
      booted_flag[idx]       <= booted_flag_next;
      ready_flag[idx]        <= ready_flag_next;
      ok_flag[idx]           <= ok_flag_next;
      enc_ok_flag[idx]       <= enc_ok_flag_next;
      last_setpoint[idx]     <= last_setpoint_next;
      current_control[idx]   <= current_control_next;
      held_target[idx]       <= held_target_next;
      held_offset[idx]       <= held_offset_next;
      state_code[idx]        <= state_code_next;
    end
  end

endmodule

// ----- src/dpss_checker.sv -----
// port-level checks for the drive power state sequencer
module dpss_checker
  import dpss_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  s_tready,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata
);

  out_item_t res;
  assign res = out_item_t'(m_tdata[$bits(out_item_t)-1:0]);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // input side only stalls behind a stalled result
  a_in_stall: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid && !m_tready)
    else $error("input stalled without output back-pressure");

  // ready only after boot and only in ready or operation enabled
  a_ready_state: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && res.drive_ready |->
      res.booted && (res.drive_state == DS_READY || res.drive_state == DS_OP_ENABLED))
    else $error("ready flag outside ready states");

endmodule

bind drive_power_state_sequencer dpss_checker u_dpss_checker (.*);
